>>> rtl/core/ghst_pkg.sv
package ghst_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int MAX_DEPTH_DEF = 8;

	localparam int IDX_W    = 16;
	localparam int GEN_W    = 16;
	localparam int HANDLE_W = 32;

	localparam logic [GEN_W-1:0] GEN_STEP = 16'd2;

	// request codes
	localparam logic [2:0] REQ_ALLOC    = 3'd0;
	localparam logic [2:0] REQ_SHUTDOWN = 3'd1;
	localparam logic [2:0] REQ_LOOKUP   = 3'd2;
	localparam logic [2:0] REQ_ENTER    = 3'd3;
	localparam logic [2:0] REQ_LEAVE    = 3'd4;
	localparam logic [2:0] REQ_SHUT_ALL = 3'd5;
	localparam logic [2:0] REQ_CURRENT  = 3'd6;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_FREE   = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_EXECUTING = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;

	typedef struct packed {
		logic [2:0]          req_type;
		logic [HANDLE_W-1:0] handle;
		logic                was_pushed;
	} req_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [HANDLE_W-1:0] handle_out;
		logic [IDX_W-1:0]    slot_index;
		logic                pushed;
		logic                stack_empty;
		logic [IDX_W-1:0]    rebind_slot;
	} rsp_t;

	// probe walking the call stack row
	typedef struct packed {
		logic             act;
		logic [IDX_W-1:0] idx;
		logic             hit;
	} stk_probe_t;

	// probe walking the slot row
	typedef struct packed {
		logic             act;
		logic [2:0]       req;
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
		logic             busy;    // slot is on the call stack
		logic             found;   // slot claimed or handle valid
		logic [GEN_W-1:0] gen_hit; // generation of the claimed slot
		logic [IDX_W-1:0] slot;
	} slot_probe_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctrl_t;

endpackage

>>> rtl/core/ghst_if.sv
interface ghst_req_if;
	import ghst_pkg::*;

	logic valid;
	logic ready;
	req_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface ghst_rsp_if;
	import ghst_pkg::*;

	logic valid;
	logic ready;
	rsp_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> rtl/core/ghst_stack_cell.sv
module ghst_stack_cell #(
	parameter int POS = 0,
	parameter int IW  = 4,
	parameter int DW  = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ghst_pkg::stk_ctrl_t  ctrl,
	input  logic [DW-1:0]        depth,
	input  logic [IW-1:0]        from_up,
	input  logic [IW-1:0]        from_dn,
	output logic [IW-1:0]        entry,
	input  ghst_pkg::stk_probe_t probe_in,
	output ghst_pkg::stk_probe_t probe_out
);
	import ghst_pkg::*;

	localparam logic [DW-1:0] POS_D = DW'(POS);

	logic [IW-1:0] entry_q;
	stk_probe_t    probe_q;
	stk_probe_t    probe_d;
	logic          in_use;

	assign in_use = depth > POS_D;

	// push shifts toward the bottom, pop toward the top
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			entry_q <= from_up;
		end else if (ctrl.pop) begin
			entry_q <= from_dn;
		end
	end

	always_comb begin
		probe_d = probe_in;
		if (in_use && (IDX_W'(entry_q) == probe_in.idx)) begin
			probe_d.hit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
		end
	end

	assign entry     = entry_q;
	assign probe_out = probe_q;

endmodule

>>> rtl/core/ghst_slot_cell.sv
module ghst_slot_cell #(
	parameter int POS = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ghst_pkg::slot_probe_t probe_in,
	output ghst_pkg::slot_probe_t probe_out
);
	import ghst_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(POS);

	logic             used_q;
	logic [GEN_W-1:0] gen_q;
	logic             used_d;
	logic [GEN_W-1:0] gen_d;
	slot_probe_t      probe_d;
	slot_probe_t      probe_q;
	logic             live;

	assign live = (probe_in.idx == MY_IDX) && used_q && (gen_q == probe_in.gen);

	always_comb begin
		probe_d = probe_in;
		used_d  = used_q;
		gen_d   = gen_q;
		if (probe_in.act) begin
			case (probe_in.req)
				REQ_ALLOC: begin
					// first free cell along the row takes it
					if (!probe_in.found && !used_q) begin
						used_d          = 1'b1;
						probe_d.found   = 1'b1;
						probe_d.slot    = MY_IDX;
						probe_d.gen_hit = gen_q;
					end
				end
				REQ_SHUTDOWN, REQ_LOOKUP, REQ_ENTER: begin
					if (live) begin
						probe_d.found = 1'b1;
						probe_d.slot  = MY_IDX;
						if ((probe_in.req == REQ_SHUTDOWN) && !probe_in.busy) begin
							used_d = 1'b0;
							gen_d  = gen_q + GEN_STEP;
						end
					end
				end
				REQ_SHUT_ALL: begin
					if (used_q) begin
						used_d = 1'b0;
						gen_d  = gen_q + GEN_STEP;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			gen_q   <= '0;
			probe_q <= '0;
		end else begin
			used_q  <= used_d;
			gen_q   <= gen_d;
			probe_q <= probe_d;
		end
	end

	assign probe_out = probe_q;

endmodule

>>> rtl/core/generation_handle_slot_table_core.sv
// Channel   | Modport | Payload                                     | Role
// ----------+---------+---------------------------------------------+--------------------
// request   | sink    | req_type, handle, was_pushed                | one operation
// response  | source  | status, handle_out, slot_index, pushed,     | one result per
//           |         | stack_empty, rebind_slot                    | request
//
// From accept to response register the probe walks one cell per cycle down the stack row,
// then the slot row; fin_q latches the result, and commit writes the response register.
// Only one request in flight; request.ready is high in idle only, so at best a new request
// is taken the cycle after commit. arst_n clears slot cells, stack depth and sequencer;
// stack entries are unreset, only entries below the depth are read. A stalled response
// holds the next one in commit.
module generation_handle_slot_table_core #(
	parameter int NUM_SLOTS = ghst_pkg::NUM_SLOTS_DEF,
	parameter int MAX_DEPTH = ghst_pkg::MAX_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ghst_req_if.sink   request,
	ghst_rsp_if.source response
);
	import ghst_pkg::*;

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int DW = $clog2(MAX_DEPTH + 1);

	localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);
	localparam logic [DW-1:0] DEPTH_ONE = DW'(1);

	// sequencer
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	logic [1:0]    state_q;
	logic [1:0]    state_d;
	logic          launch_q;
	req_t          item_q;
	slot_probe_t   fin_q;
	logic [DW-1:0] depth_q;
	logic [DW-1:0] depth_d;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	rsp_t          rsp_d;
	logic          accept;
	logic          commit;
	stk_ctrl_t     stk_ctrl;
	stk_ctrl_t     stk_op;

	// cell rows
	stk_probe_t    stk_probe  [MAX_DEPTH+1];
	slot_probe_t   slot_probe [NUM_SLOTS+1];
	logic [IW-1:0] stk_entry  [MAX_DEPTH];
	logic [IW-1:0] second_entry;
	logic [IW-1:0] push_idx;
	logic [IDX_W-1:0] top_ext;
	logic [IDX_W-1:0] second_ext;

	assign accept = request.valid && request.ready;
	assign commit = (state_q == S_FIN) && (!rsp_valid_q || response.ready);

	assign request.ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = S_WALK;
			S_WALK: if (slot_probe[NUM_SLOTS].act) state_d = S_FIN;
			S_FIN:  if (commit) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= 1'b0;
			depth_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= accept;
			if (commit) begin
				depth_q     <= depth_d;
				rsp_valid_q <= 1'b1;
			end else if (response.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= request.payload;
		end
		if ((state_q == S_WALK) && slot_probe[NUM_SLOTS].act) begin
			fin_q <= slot_probe[NUM_SLOTS];
		end
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	// the stack row checks whether the handle's slot is executing
	assign stk_probe[0] = '{act: launch_q, idx: item_q.handle[IDX_W-1:0], hit: 1'b0};

	assign push_idx = fin_q.slot[IW-1:0];
	assign stk_ctrl = '{push: stk_op.push && commit, pop: stk_op.pop && commit};

	for (genvar j = 0; j < MAX_DEPTH; j++) begin : g_stk
		logic [IW-1:0] up_w;
		logic [IW-1:0] dn_w;

		if (j == 0) begin : g_top
			assign up_w = push_idx;
		end else begin : g_mid_up
			assign up_w = stk_entry[j-1];
		end

		if (j == MAX_DEPTH - 1) begin : g_bottom
			assign dn_w = '0;
		end else begin : g_mid_dn
			assign dn_w = stk_entry[j+1];
		end

		ghst_stack_cell #(
			.POS (j),
			.IW  (IW),
			.DW  (DW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (stk_ctrl),
			.depth     (depth_q),
			.from_up   (up_w),
			.from_dn   (dn_w),
			.entry     (stk_entry[j]),
			.probe_in  (stk_probe[j]),
			.probe_out (stk_probe[j+1])
		);
	end

	if (MAX_DEPTH > 1) begin : g_second
		assign second_entry = stk_entry[1];
	end else begin : g_no_second
		assign second_entry = '0;
	end

	assign top_ext    = IDX_W'(stk_entry[0]);
	assign second_ext = IDX_W'(second_entry);

	// the slot row does alloc search, handle check and frees
	assign slot_probe[0] = '{
		act:     stk_probe[MAX_DEPTH].act,
		req:     item_q.req_type,
		idx:     item_q.handle[IDX_W-1:0],
		gen:     item_q.handle[HANDLE_W-1:IDX_W],
		busy:    stk_probe[MAX_DEPTH].hit,
		found:   1'b0,
		gen_hit: '0,
		slot:    '0
	};

	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
		ghst_slot_cell #(
			.POS (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.probe_in  (slot_probe[k]),
			.probe_out (slot_probe[k+1])
		);
	end

	// commit: stack update and result
	always_comb begin
		rsp_d        = '0;
		rsp_d.status = ST_OK;
		stk_op       = '0;
		depth_d      = depth_q;
		case (item_q.req_type)
			REQ_ALLOC: begin
				if (fin_q.found) begin
					rsp_d.slot_index = fin_q.slot;
					rsp_d.handle_out = {fin_q.gen_hit, fin_q.slot};
				end else begin
					rsp_d.status = ST_NO_FREE;
				end
			end
			REQ_SHUTDOWN, REQ_LOOKUP: begin
				if (!fin_q.found) begin
					rsp_d.status = ST_NOT_FOUND;
				end else begin
					rsp_d.slot_index = fin_q.slot;
					if ((item_q.req_type == REQ_SHUTDOWN) && fin_q.busy) begin
						rsp_d.status = ST_EXECUTING;
					end
				end
			end
			REQ_ENTER: begin
				if (!fin_q.found) begin
					rsp_d.status = ST_NOT_FOUND;
				end else begin
					rsp_d.slot_index = fin_q.slot;
					// re-entering the slot already on top pushes nothing
					if ((depth_q == '0) || (top_ext != fin_q.slot)) begin
						if (depth_q >= DEPTH_MAX) begin
							rsp_d.status = ST_FULL;
						end else begin
							stk_op.push  = 1'b1;
							depth_d      = depth_q + DEPTH_ONE;
							rsp_d.pushed = 1'b1;
						end
					end
				end
			end
			REQ_LEAVE: begin
				if (item_q.was_pushed) begin
					if (depth_q == '0) begin
						rsp_d.status = ST_EMPTY;
					end else begin
						stk_op.pop = 1'b1;
						depth_d    = depth_q - DEPTH_ONE;
						if (depth_q > DEPTH_ONE) begin
							rsp_d.rebind_slot = second_ext;
						end
					end
				end else if (depth_q != '0) begin
					rsp_d.rebind_slot = top_ext;
				end
			end
			REQ_SHUT_ALL: begin
				// slot cells freed themselves on the way through
				depth_d = '0;
			end
			REQ_CURRENT: begin
				if (depth_q == '0) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.slot_index = top_ext;
				end
			end
			default: begin
			end
		endcase
		rsp_d.stack_empty = (depth_d == '0);
	end

	assign response.valid   = rsp_valid_q;
	assign response.payload = rsp_q;

	// a push never goes past the last stack cell
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		stk_ctrl.push |-> (depth_q < DEPTH_MAX))
		else $error("push with full stack");

	// while ready, no probe walks either row
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		request.ready |-> (!launch_q && !stk_probe[MAX_DEPTH].act && !slot_probe[NUM_SLOTS].act))
		else $error("probe active while idle");

	// every commit shows a response in the next cycle
	a_commit_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> response.valid)
		else $error("commit without response");

	// push and pop never in the same commit
	a_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !(stk_ctrl.push && stk_ctrl.pop))
		else $error("push and pop together");

endmodule
